/* design/keyframe_scale_interpolator_macros.svh */
// Assertion helpers shared by the design files.
`ifndef KEYFRAME_SCALE_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_SCALE_INTERPOLATOR_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define KSI_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition implies a second one in the next cycle.
`define KSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/ksi_pkg.sv */
`timescale 1ns / 1ps
package ksi_pkg;

  typedef enum logic [1:0] {
    CMD_EVAL   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_EVALUATED = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_UPDATED   = 3'd3,
    ST_FULL      = 3'd4,
    ST_DELETED   = 3'd5,
    ST_NOTFOUND  = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] total_life;
    logic [23:0] remaining_life;
    logic [23:0] base_width;
    logic [23:0] base_height;
    logic [23:0] key_time;
    logic [15:0] key_wscale;
    logic [15:0] key_hscale;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] new_width;
    logic [23:0] new_height;
    logic [4:0]  slot;
  } out_item_t;

  typedef struct packed {
    logic [23:0] t;
    logic [15:0] ws;
    logic [15:0] hs;
  } key_t;

  // Weight divider control.
  typedef struct packed {
    logic        start;
    logic [23:0] num;
    logic [23:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_RDPAIR,
    S_DIV,
    S_BLW0,
    S_BLW1,
    S_BLH0,
    S_BLH1,
    S_MW,
    S_MH,
    S_SHIFT,
    S_OUT
  } state_e;

endpackage

/* design/ksi_div.sv */
`timescale 1ns / 1ps
`include "keyframe_scale_interpolator_macros.svh"
// Restoring divider: one quotient bit per cycle, floor((num << 16) / den)
// clamped to 65536.
module ksi_div
  import ksi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int QBITS = 41;

  logic [24:0] rem_q, rem_d;
  logic [40:0] num_q, num_d;
  logic [40:0] quo_q, quo_d;
  logic [23:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [24:0] trial;

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[23:0], num_q[40]};
    if (req_i.start) begin
      rem_d  = '0;
      num_d  = {1'b0, req_i.num, 16'd0};
      quo_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 6'(QBITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[39:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[39:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[39:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = (quo_q > 41'd65536) ? 17'd65536 : quo_q[16:0];

  `KSI_ASSERT(a_done_pulse, !(done_q && busy_q))
  `KSI_ASSERT_NEXT(a_cnt_run, busy_q && !req_i.start && cnt_q == 6'd1, done_q)
  `KSI_ASSERT(a_cnt_idle, busy_q || cnt_q == 6'd0)

endmodule

/* design/keyframe_scale_interpolator.sv */
`timescale 1ns / 1ps
// Keyframe scale interpolator. Keeps up to KEY_DEPTH keys sorted by time,
// in a table memory with one read and one write port. Each transfer takes one
// command and gives one result; the block is not ready while a command is at
// work. Insert and delete run as a table walk that reads one key a cycle:
// the search stops at the key's place and the shift walks the rest. Evaluate
// searches for the pair of keys around the age; when the age falls between
// two keys it runs a bit-serial weight division and blends the scales through
// the one shared 32x32 multiplier, and the same multiplier then scales the
// base size before the result is loaded. The next command is taken in the
// cycle after the result is loaded. Results sit in an output register and are
// held until taken; a result that waits there does not block the next command,
// only the loading of its result.
`include "keyframe_scale_interpolator_macros.svh"
module keyframe_scale_interpolator
  import ksi_pkg::*;
#(
  parameter int KEY_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int CW = $clog2(KEY_DEPTH + 1);

  // Memory
  key_t          mem [KEY_DEPTH];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  key_t          wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  state_e       state_q, state_d;
  in_item_t     item_q, item_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;   // index being read
  logic          rv_q, rv_d;      // rdata_q holds entry idx_q-1
  logic          mode_q, mode_d;  // 0 search, 1 shift
  key_t          prev_q, prev_d;
  key_t          cur_q, cur_d;
  logic [23:0]   age_q, age_d;
  logic [15:0]   sw_q, sw_d, sh_q, sh_d;
  logic [63:0]   acc_q, acc_d;
  logic [63:0]   prod_q;
  logic [31:0]   ma, mb;
  logic [16:0]   w_q, w_d;
  out_item_t     res_q, res_d;
  out_item_t     out_q, out_d;
  logic          ov_q, ov_d;
  logic [CW-1:0] hit_q, hit_d;
  div_req_t      dreq;
  div_rsp_t      drsp;

  ksi_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // Shared multiplier, registered.
  always_ff @(posedge clk_i) prod_q <= ma * mb;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  function automatic logic [23:0] sat24(input logic [63:0] v);
    logic [51:0] s;
    s = v[63:12] + 52'((v[11] == 1'b1) ? 1 : 0);
    return (s > 52'hFFFFFF) ? 24'hFFFFFF : s[23:0];
  endfunction

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    count_d = count_q;
    idx_d   = idx_q;
    rv_d    = 1'b0;
    mode_d  = mode_q;
    prev_d  = prev_q;
    cur_d   = cur_q;
    age_d   = age_q;
    sw_d    = sw_q;
    sh_d    = sh_q;
    acc_d   = acc_q;
    w_d     = w_q;
    res_d   = res_q;
    out_d   = out_q;
    ov_d    = ov_q;
    hit_d   = hit_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    raddr   = AW'(idx_q);
    ma      = '0;
    mb      = '0;
    dreq    = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          item_d = in_data_i;
          age_d  = (in_data_i.total_life >= in_data_i.remaining_life) ?
                   in_data_i.total_life - in_data_i.remaining_life : 24'd0;
          idx_d  = '0;
          mode_d = 1'b0;
          res_d  = '0;
          res_d.status = ST_NOTFOUND;
          if (in_data_i.cmd == CMD_NONE) begin
            state_d = S_OUT;
          end else if (in_data_i.cmd == CMD_EVAL && count_q == '0) begin
            res_d.status = ST_EMPTY;
            state_d = S_OUT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      // Read one entry a cycle; rdata_q holds entry idx_q-1 when rv_q.
      S_SCAN: begin
        if (mode_q) begin
          // Shift pass: insert moves up from the top, delete moves down.
          if (item_q.cmd == CMD_INSERT) begin
            if (idx_q == hit_q && !rv_q) begin
              we = 1'b1;
              waddr = AW'(hit_q);
              wdata = '{t: item_q.key_time, ws: item_q.key_wscale,
                        hs: item_q.key_hscale};
              count_d = count_q + CW'(1);
              res_d.status = ST_INSERTED;
              res_d.slot = 5'(hit_q);
              state_d = S_OUT;
            end else if (rv_q) begin
              // Move entry idx_q-1 up to idx_q, fetch the next one below.
              we = 1'b1;
              waddr = AW'(idx_q);
              wdata = rdata_q;
              idx_d = idx_q - CW'(1);
              if (idx_q - CW'(1) != hit_q) begin
                raddr = AW'(idx_q - CW'(2));
                rv_d  = 1'b1;
              end
            end else begin
              raddr = AW'(idx_q - CW'(1));
              rv_d  = 1'b1;
            end
          end else begin
            if (rv_q) begin
              we = 1'b1;
              waddr = AW'(idx_q - CW'(2));
              wdata = rdata_q;
            end
            if (idx_q == count_q) begin
              count_d = count_q - CW'(1);
              res_d.status = ST_DELETED;
              res_d.slot = 5'(hit_q);
              state_d = S_OUT;
            end else begin
              raddr = AW'(idx_q);
              idx_d = idx_q + CW'(1);
              rv_d  = 1'b1;
            end
          end
        end else begin
          if (rv_q) begin
            // Compare entry idx_q-1.
            cur_d  = rdata_q;
            prev_d = cur_q;
            unique case (item_q.cmd)
              CMD_EVAL: begin
                if (age_q <= rdata_q.t) begin
                  if (idx_q == CW'(1)) begin
                    sw_d = rdata_q.ws;
                    sh_d = rdata_q.hs;
                    state_d = S_MW;
                  end else begin
                    state_d = S_RDPAIR;
                  end
                end
              end
              CMD_INSERT: begin
                if (rdata_q.t >= item_q.key_time) begin
                  hit_d = idx_q - CW'(1);
                  if (rdata_q.t == item_q.key_time) begin
                    we = 1'b1;
                    waddr = AW'(idx_q - CW'(1));
                    wdata = '{t: rdata_q.t, ws: item_q.key_wscale,
                              hs: item_q.key_hscale};
                    res_d.status = ST_UPDATED;
                    res_d.slot = 5'(idx_q - CW'(1));
                    state_d = S_OUT;
                  end else if (count_q == CW'(KEY_DEPTH)) begin
                    res_d.status = ST_FULL;
                    state_d = S_OUT;
                  end else begin
                    mode_d = 1'b1;
                    idx_d  = count_q;
                  end
                end
              end
              default: begin
                if (rdata_q.t == item_q.key_time) begin
                  hit_d  = idx_q - CW'(1);
                  mode_d = 1'b1;
                end
              end
            endcase
          end
          if (state_d == S_SCAN && mode_d == mode_q) begin
            if (idx_q == count_q) begin
              if (item_q.cmd == CMD_EVAL) begin
                sw_d = (rv_q ? rdata_q.ws : cur_q.ws);
                sh_d = (rv_q ? rdata_q.hs : cur_q.hs);
                state_d = S_MW;
              end else if (item_q.cmd == CMD_INSERT) begin
                if (count_q == CW'(KEY_DEPTH)) begin
                  res_d.status = ST_FULL;
                  state_d = S_OUT;
                end else begin
                  hit_d  = count_q;
                  mode_d = 1'b1;
                end
              end else begin
                state_d = S_OUT;
              end
            end else begin
              raddr = AW'(idx_q);
              idx_d = idx_q + CW'(1);
              rv_d  = 1'b1;
            end
          end
        end
      end

      S_RDPAIR: begin
        dreq.start = 1'b1;
        dreq.num   = (age_q > prev_q.t) ? age_q - prev_q.t : 24'd0;
        dreq.den   = (cur_q.t > prev_q.t) ? cur_q.t - prev_q.t : 24'd1;
        state_d    = S_DIV;
      end

      S_DIV: begin
        if (drsp.done) begin
          w_d = drsp.quo;
          state_d = S_BLW0;
        end
      end

      S_BLW0: begin
        ma = 32'(prev_q.ws);
        mb = 32'(17'd65536 - w_q);
        state_d = S_BLW1;
      end
      S_BLW1: begin
        acc_d = prod_q + 64'd32768;
        ma = 32'(cur_q.ws);
        mb = 32'(w_q);
        state_d = S_BLH0;
      end
      S_BLH0: begin
        sw_d = 16'((acc_q + prod_q) >> 16);
        ma = 32'(prev_q.hs);
        mb = 32'(17'd65536 - w_q);
        state_d = S_BLH1;
      end
      S_BLH1: begin
        acc_d = prod_q + 64'd32768;
        ma = 32'(cur_q.hs);
        mb = 32'(w_q);
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        sh_d = 16'((acc_q + prod_q) >> 16);
        state_d = S_MW;
      end
      S_MW: begin
        ma = 32'(item_q.base_width);
        mb = 32'(sw_q);
        state_d = S_MH;
      end
      S_MH: begin
        acc_d = prod_q;
        ma = 32'(item_q.base_height);
        mb = 32'(sh_q);
        res_d.status = ST_EVALUATED;
        state_d = S_OUT;
        idx_d = '1;
      end

      S_OUT: begin
        // Hold the height product while the previous result waits.
        ma = 32'(item_q.base_height);
        mb = 32'(sh_q);
        if (!ov_q || out_ready_i) begin
          out_d = res_q;
          if (item_q.cmd == CMD_EVAL && res_q.status == ST_EVALUATED) begin
            out_d.new_width  = sat24(acc_q);
            out_d.new_height = sat24(prod_q);
          end
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ov_q    <= 1'b0;
      rv_q    <= 1'b0;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
      rv_q    <= rv_d;
      mode_q  <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    idx_q  <= idx_d;
    prev_q <= prev_d;
    cur_q  <= cur_d;
    age_q  <= age_d;
    sw_q   <= sw_d;
    sh_q   <= sh_d;
    acc_q  <= acc_d;
    w_q    <= w_d;
    res_q  <= res_d;
    out_q  <= out_d;
    hit_q  <= hit_d;
  end

  `KSI_ASSERT(a_count_range, count_q <= CW'(KEY_DEPTH))
  `KSI_ASSERT(a_ready_idle, !in_ready_o || state_q == S_IDLE)
  `KSI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `KSI_ASSERT(a_no_write_idle, !(we && state_q == S_IDLE))

endmodule
